// ----- sv/ggs_pkg.sv -----
// shared types, constants and register codes of the grid greeks stencil unit
package ggs_pkg;

   localparam int MAX_PRICE_POINTS_DEF = 1024;
   localparam int MAX_TIME_STEPS_DEF = 4096;
   localparam int VALUE_WIDTH_DEF = 32;

   localparam int RESULT_WIDTH = 48;
   localparam int PIDX_WIDTH = 11;
   localparam int TIDX_WIDTH = 12;
   localparam int PP_WIDTH = 11;
   localparam int TS_WIDTH = 13;
   localparam int REG_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int DIGIT_WIDTH = 16;
   localparam int FRAC_SHIFT = 16;
   localparam int RSP_DEPTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRICE_POINTS = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIME_STEPS = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRICE_STEP = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INV_PRICE_STEP = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INV_PRICE_STEP_SQ = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VOLATILITY = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INV_TIME_STEP = 3'd6;

   localparam logic [PP_WIDTH-1:0] PRICE_POINTS_RST = 11'd100;
   localparam logic [TS_WIDTH-1:0] TIME_STEPS_RST = 13'd100;
   localparam logic [REG_WIDTH-1:0] PRICE_STEP_RST = 32'd131072;
   localparam logic [REG_WIDTH-1:0] INV_PRICE_STEP_RST = 32'd32768;
   localparam logic [REG_WIDTH-1:0] INV_PRICE_STEP_SQ_RST = 32'd16384;
   localparam logic [REG_WIDTH-1:0] VOLATILITY_RST = 32'd13107;
   localparam logic [REG_WIDTH-1:0] INV_TIME_STEP_RST = 32'd6553600;

   localparam logic KIND_GREEKS = 1'b0;
   localparam logic KIND_THETA = 1'b1;

   localparam logic signed [RESULT_WIDTH-1:0] SAT_MAX = {1'b0, {(RESULT_WIDTH-1){1'b1}}};
   localparam logic signed [RESULT_WIDTH-1:0] SAT_MIN = {1'b1, {(RESULT_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic                           kind;
      logic [PIDX_WIDTH-1:0]          price_index;
      logic [TIDX_WIDTH-1:0]          time_index;
      logic signed [RESULT_WIDTH-1:0] delta;
      logic signed [RESULT_WIDTH-1:0] gamma;
      logic signed [RESULT_WIDTH-1:0] rho_term;
      logic signed [RESULT_WIDTH-1:0] vega_term;
      logic signed [RESULT_WIDTH-1:0] theta;
      logic                           last;
   } rsp_word_type;

   typedef struct packed {
      logic start;
      logic shift17;
   } mul_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_sts_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_sts_type;

endpackage

// ----- sv/ggs_if.sv -----
// request and response channel interfaces of the grid greeks stencil unit
interface ggs_req_if #(parameter int VALUE_WIDTH = ggs_pkg::VALUE_WIDTH_DEF);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] grid_value;

   modport source (output valid, output grid_value, input ready);
   modport sink (input valid, input grid_value, output ready);
endinterface

interface ggs_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    kind;
   logic [ggs_pkg::PIDX_WIDTH-1:0]          price_index;
   logic [ggs_pkg::TIDX_WIDTH-1:0]          time_index;
   logic signed [ggs_pkg::RESULT_WIDTH-1:0] delta;
   logic signed [ggs_pkg::RESULT_WIDTH-1:0] gamma;
   logic signed [ggs_pkg::RESULT_WIDTH-1:0] rho_term;
   logic signed [ggs_pkg::RESULT_WIDTH-1:0] vega_term;
   logic signed [ggs_pkg::RESULT_WIDTH-1:0] theta;
   logic                                    last;

   modport source (output valid, output kind, output price_index, output time_index,
                   output delta, output gamma, output rho_term, output vega_term,
                   output theta, output last, input ready);
   modport sink (input valid, input kind, input price_index, input time_index,
                 input delta, input gamma, input rho_term, input vega_term,
                 input theta, input last, output ready);
endinterface

// ----- sv/grid_greeks_stencil_unit.sv -----
// top level: finite-difference greeks and theta over a streamed option price grid
//
//   channel   dir  handshake     word
//   req_ch    in   valid/ready   grid_value, one grid point, column-major
//   rsp_ch    out  valid/ready   kind, indices, delta, gamma, rho, vega, theta, last
//   csr_*     in   csr_we        csr_index, csr_wdata
//
// one word at a time; every multiply runs on the shared multiplier, which sets the rate
// later-column word: the theta multiply; column-zero word from row 2 on: the delta,
// gamma, rho, vega-factor and vega multiplies, plus the row-zero delta at row 2 and
// the edge delta when the held edge result goes out first
// two-entry response queue lets the next word in while results wait
// synchronous active-high reset; column store is not cleared
module grid_greeks_stencil_unit #(
   parameter int MAX_PRICE_POINTS = ggs_pkg::MAX_PRICE_POINTS_DEF,
   parameter int MAX_TIME_STEPS = ggs_pkg::MAX_TIME_STEPS_DEF,
   parameter int VALUE_WIDTH = ggs_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   ggs_req_if.sink                                req_ch,
   ggs_rsp_if.source                              rsp_ch,
   input  logic                                   csr_we,
   input  logic [ggs_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [ggs_pkg::REG_WIDTH-1:0]          csr_wdata
);

   localparam int RSW = ggs_pkg::RESULT_WIDTH;
   localparam int REGW = ggs_pkg::REG_WIDTH;
   localparam int PPW = ggs_pkg::PP_WIDTH;
   localparam int TSW = ggs_pkg::TS_WIDTH;
   localparam int DEPTH = MAX_PRICE_POINTS + 1;
   localparam int RW = $clog2(DEPTH);
   localparam int CW = $clog2(MAX_TIME_STEPS + 1);
   localparam int PW = (RW > PPW) ? RW : PPW;
   localparam int TW = (CW > TSW) ? CW : TSW;
   localparam int AW = (VALUE_WIDTH + 2 > RSW) ? VALUE_WIDTH + 2 : RSW;
   localparam int BW = (RW + REGW > RSW) ? RW + REGW : RSW;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_EDGE, ST_EDGE_OUT, ST_THETA, ST_THETA_OUT,
      ST_DELTA, ST_GRAW, ST_RHO, ST_WVOL, ST_XVOL, ST_VEGA,
      ST_ZERO, ST_ZERO_OUT, ST_ROW_OUT, ST_UPDATE
   } state_type;

   // configuration registers
   logic [PPW-1:0]  pp_ff;
   logic [TSW-1:0]  ts_ff;
   logic [REGW-1:0] price_step_ff;
   logic [REGW-1:0] inv_ps_ff;
   logic [REGW-1:0] inv_ps_sq_ff;
   logic [REGW-1:0] vol_ff;
   logic [REGW-1:0] inv_ts_ff;

   state_type                     state_ff;
   logic                          issued_ff;
   logic                          edge_pend_ff;
   logic [RW-1:0]                 edge_idx_ff;
   logic [RW-1:0]                 row_ff;
   logic [CW-1:0]                 col_ff;
   logic signed [VALUE_WIDTH-1:0] older_ff;
   logic signed [VALUE_WIDTH-1:0] newer_ff;
   logic signed [VALUE_WIDTH-1:0] cur_ff;
   logic [BW-1:0]                 s_ff;
   logic signed [RSW-1:0]         delta_ff;
   logic signed [RSW-1:0]         graw_ff;
   logic signed [RSW-1:0]         rho_ff;
   logic signed [RSW-1:0]         vega_ff;
   logic signed [RSW-1:0]         tmp_ff;
   logic signed [RSW-1:0]         held_rho_ff;
   logic signed [RSW-1:0]         held_vega_ff;

   logic                          accept;
   logic [PW-1:0]                 pp_ext;
   logic [PW-1:0]                 m_eff;
   logic [TW-1:0]                 ts_ext;
   logic [TW-1:0]                 n_eff;
   logic [RW-1:0]                 row_m1;
   logic [CW-1:0]                 col_m1;
   logic signed [VALUE_WIDTH-1:0] prev_value;
   logic signed [AW-1:0]          cur_x;
   logic signed [AW-1:0]          older_x;
   logic signed [AW-1:0]          newer_x;
   logic signed [AW-1:0]          prev_x;
   logic signed [AW-1:0]          mul_a;
   logic [BW-1:0]                 mul_b;
   logic                          mul_shift17;
   logic                          is_mul;
   logic                          is_out;
   ggs_pkg::mul_ctl_type          mul_ctl;
   ggs_pkg::mul_sts_type          mul_sts;
   logic signed [RSW-1:0]         mul_res;
   logic signed [RSW+1:0]         rho_sum;
   logic signed [RSW-1:0]         rho_sat;
   state_type                     body_state;
   logic                          push;
   ggs_pkg::rsp_word_type         push_word;
   ggs_pkg::rsp_word_type         head_word;
   ggs_pkg::fifo_sts_type         fifo_sts;
   logic                          pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_ff         <= ggs_pkg::PRICE_POINTS_RST;
         ts_ff         <= ggs_pkg::TIME_STEPS_RST;
         price_step_ff <= ggs_pkg::PRICE_STEP_RST;
         inv_ps_ff     <= ggs_pkg::INV_PRICE_STEP_RST;
         inv_ps_sq_ff  <= ggs_pkg::INV_PRICE_STEP_SQ_RST;
         vol_ff        <= ggs_pkg::VOLATILITY_RST;
         inv_ts_ff     <= ggs_pkg::INV_TIME_STEP_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            ggs_pkg::CSR_PRICE_POINTS:      pp_ff <= csr_wdata[PPW-1:0];
            ggs_pkg::CSR_TIME_STEPS:        ts_ff <= csr_wdata[TSW-1:0];
            ggs_pkg::CSR_PRICE_STEP:        price_step_ff <= csr_wdata;
            ggs_pkg::CSR_INV_PRICE_STEP:    inv_ps_ff <= csr_wdata;
            ggs_pkg::CSR_INV_PRICE_STEP_SQ: inv_ps_sq_ff <= csr_wdata;
            ggs_pkg::CSR_VOLATILITY:        vol_ff <= csr_wdata;
            ggs_pkg::CSR_INV_TIME_STEP:     inv_ts_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamped grid size
   assign pp_ext = PW'(pp_ff);
   assign m_eff = (pp_ext < PW'(2)) ? PW'(2) :
                  (pp_ext > PW'(MAX_PRICE_POINTS)) ? PW'(MAX_PRICE_POINTS) : pp_ext;
   assign ts_ext = TW'(ts_ff);
   assign n_eff = (ts_ext > TW'(MAX_TIME_STEPS)) ? TW'(MAX_TIME_STEPS) : ts_ext;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept = req_ch.valid && req_ch.ready;

   assign row_m1 = row_ff - RW'(1);
   assign col_m1 = col_ff - CW'(1);
   assign cur_x = AW'(cur_ff);
   assign older_x = AW'(older_ff);
   assign newer_x = AW'(newer_ff);
   assign prev_x = AW'(prev_value);

   assign body_state = (col_ff != '0) ? ST_THETA :
                       (row_ff >= RW'(2)) ? ST_DELTA : ST_UPDATE;

   always_comb begin
      mul_a       = newer_x - older_x;
      mul_b       = BW'(inv_ps_ff);
      mul_shift17 = 1'b0;
      is_mul      = 1'b1;
      is_out      = 1'b0;
      unique case (state_ff) inside
         ST_EDGE, ST_ZERO: begin
            mul_a = newer_x - older_x;
            mul_b = BW'(inv_ps_ff);
         end
         ST_THETA: begin
            mul_a = cur_x - prev_x;
            mul_b = BW'(inv_ts_ff);
         end
         ST_DELTA: begin
            mul_a       = cur_x - older_x;
            mul_b       = BW'(inv_ps_ff);
            mul_shift17 = 1'b1;
         end
         ST_GRAW: begin
            mul_a = cur_x - (newer_x <<< 1) + older_x;
            mul_b = BW'(inv_ps_sq_ff);
         end
         ST_RHO: begin
            mul_a = AW'(delta_ff);
            mul_b = s_ff;
         end
         ST_WVOL: begin
            mul_a = signed'(AW'(vol_ff));
            mul_b = s_ff;
         end
         ST_XVOL: begin
            mul_a = AW'(tmp_ff);
            mul_b = s_ff;
         end
         ST_VEGA: begin
            // x is never negative
            mul_a = AW'(graw_ff);
            mul_b = BW'(tmp_ff[RSW-1:0]);
         end
         ST_EDGE_OUT, ST_THETA_OUT, ST_ZERO_OUT, ST_ROW_OUT: begin
            is_mul = 1'b0;
            is_out = 1'b1;
         end
         default: begin
            is_mul = 1'b0;
         end
      endcase
   end

   assign mul_ctl.start = is_mul && !issued_ff;
   assign mul_ctl.shift17 = mul_shift17;

   ggs_mul #(.A_WIDTH(AW), .B_WIDTH(BW)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mul_ctl),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .sts    (mul_sts),
      .result (mul_res)
   );

   ggs_colmem #(.DEPTH(DEPTH), .DATA_WIDTH(VALUE_WIDTH)) u_colmem (
      .clock   (clock),
      .wr_en   (state_ff == ST_READ),
      .wr_addr (row_ff),
      .wr_data (cur_ff),
      .rd_en   (accept),
      .rd_addr (row_ff),
      .rd_data (prev_value)
   );

   assign rho_sum = (RSW+2)'(mul_res) - (RSW+2)'(newer_ff);
   assign rho_sat = (rho_sum > (RSW+2)'(ggs_pkg::SAT_MAX)) ? ggs_pkg::SAT_MAX :
                    (rho_sum < (RSW+2)'(ggs_pkg::SAT_MIN)) ? ggs_pkg::SAT_MIN :
                    RSW'(rho_sum);

   always_comb begin
      push_word.kind        = ggs_pkg::KIND_GREEKS;
      push_word.price_index = ggs_pkg::PIDX_WIDTH'(row_m1);
      push_word.time_index  = '0;
      push_word.delta       = delta_ff;
      push_word.gamma       = (row_ff == RW'(2)) ? '0 : graw_ff;
      push_word.rho_term    = rho_ff;
      push_word.vega_term   = vega_ff;
      push_word.theta       = '0;
      push_word.last        = 1'b1;
      unique case (state_ff) inside
         ST_EDGE_OUT: begin
            push_word.price_index = ggs_pkg::PIDX_WIDTH'(edge_idx_ff);
            push_word.delta       = tmp_ff;
            push_word.gamma       = '0;
            push_word.rho_term    = held_rho_ff;
            push_word.vega_term   = held_vega_ff;
            push_word.last        = !((col_ff != '0) || (row_ff >= RW'(2)));
         end
         ST_THETA_OUT: begin
            push_word.kind        = ggs_pkg::KIND_THETA;
            push_word.price_index = ggs_pkg::PIDX_WIDTH'(row_ff);
            push_word.time_index  = ggs_pkg::TIDX_WIDTH'(col_m1);
            push_word.delta       = '0;
            push_word.gamma       = '0;
            push_word.rho_term    = '0;
            push_word.vega_term   = '0;
            push_word.theta       = tmp_ff;
         end
         ST_ZERO_OUT: begin
            push_word.price_index = '0;
            push_word.delta       = tmp_ff;
            push_word.gamma       = '0;
            push_word.last        = 1'b0;
         end
         default: ;
      endcase
   end

   assign push = is_out && !fifo_sts.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         edge_pend_ff <= 1'b0;
         edge_idx_ff  <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         older_ff     <= '0;
         newer_ff     <= '0;
         held_rho_ff  <= '0;
         held_vega_ff <= '0;
      end else begin
         if (mul_ctl.start) begin
            issued_ff <= 1'b1;
         end else if (mul_sts.done) begin
            issued_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  cur_ff   <= req_ch.grid_value;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               s_ff     <= BW'(row_m1) * BW'(price_step_ff);
               state_ff <= edge_pend_ff ? ST_EDGE : body_state;
            end
            ST_EDGE: begin
               if (mul_sts.done) begin
                  tmp_ff   <= mul_res;
                  state_ff <= ST_EDGE_OUT;
               end
            end
            ST_EDGE_OUT: begin
               if (push) begin
                  edge_pend_ff <= 1'b0;
                  state_ff     <= body_state;
               end
            end
            ST_THETA: begin
               if (mul_sts.done) begin
                  tmp_ff   <= mul_res;
                  state_ff <= ST_THETA_OUT;
               end
            end
            ST_THETA_OUT: begin
               if (push) begin
                  state_ff <= ST_UPDATE;
               end
            end
            ST_DELTA: begin
               if (mul_sts.done) begin
                  delta_ff <= mul_res;
                  state_ff <= ST_GRAW;
               end
            end
            ST_GRAW: begin
               if (mul_sts.done) begin
                  graw_ff  <= mul_res;
                  state_ff <= ST_RHO;
               end
            end
            ST_RHO: begin
               if (mul_sts.done) begin
                  rho_ff   <= rho_sat;
                  state_ff <= ST_WVOL;
               end
            end
            ST_WVOL: begin
               if (mul_sts.done) begin
                  tmp_ff   <= mul_res;
                  state_ff <= ST_XVOL;
               end
            end
            ST_XVOL: begin
               if (mul_sts.done) begin
                  tmp_ff   <= mul_res;
                  state_ff <= ST_VEGA;
               end
            end
            ST_VEGA: begin
               if (mul_sts.done) begin
                  vega_ff  <= mul_res;
                  state_ff <= (row_ff == RW'(2)) ? ST_ZERO : ST_ROW_OUT;
               end
            end
            ST_ZERO: begin
               if (mul_sts.done) begin
                  tmp_ff   <= mul_res;
                  state_ff <= ST_ZERO_OUT;
               end
            end
            ST_ZERO_OUT: begin
               if (push) begin
                  state_ff <= ST_ROW_OUT;
               end
            end
            ST_ROW_OUT: begin
               if (push) begin
                  held_rho_ff  <= rho_ff;
                  held_vega_ff <= vega_ff;
                  state_ff     <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               if (col_ff == '0) begin
                  older_ff <= newer_ff;
                  newer_ff <= cur_ff;
               end
               if (PW'(row_ff) >= m_eff) begin
                  // column end; top edge of column zero goes out with the next word
                  if (col_ff == '0) begin
                     edge_pend_ff <= 1'b1;
                     edge_idx_ff  <= row_ff;
                  end
                  row_ff <= '0;
                  col_ff <= (TW'(col_ff) >= n_eff) ? '0 : col_ff + CW'(1);
               end else begin
                  row_ff <= row_ff + RW'(1);
               end
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   ggs_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .head_word (head_word),
      .sts       (fifo_sts)
   );

   assign rsp_ch.valid = !fifo_sts.empty;
   assign pop = rsp_ch.valid && rsp_ch.ready;
   assign rsp_ch.kind = head_word.kind;
   assign rsp_ch.price_index = head_word.price_index;
   assign rsp_ch.time_index = head_word.time_index;
   assign rsp_ch.delta = head_word.delta;
   assign rsp_ch.gamma = head_word.gamma;
   assign rsp_ch.rho_term = head_word.rho_term;
   assign rsp_ch.vega_term = head_word.vega_term;
   assign rsp_ch.theta = head_word.theta;
   assign rsp_ch.last = head_word.last;

`ifndef ASSERT_OFF
   a_mul_start_idle: assert property (@(posedge clock) disable iff (reset)
      mul_ctl.start |-> !mul_sts.busy)
      else $error("multiply started while the multiplier is busy");

   a_mul_done_issued: assert property (@(posedge clock) disable iff (reset)
      mul_sts.done |-> issued_ff)
      else $error("multiply result without an issued operation");

   a_edge_at_row_zero: assert property (@(posedge clock) disable iff (reset)
      edge_pend_ff |-> (row_ff == '0))
      else $error("held edge result while the row counter is not at zero");

   a_read_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_READ))
      else $error("accepted word not followed by the column read");
`endif

endmodule

// ----- sv/ggs_mul.sv -----
// digit-serial signed by unsigned multiplier with floor shift and 48-bit saturation
module ggs_mul #(
   parameter int A_WIDTH = ggs_pkg::RESULT_WIDTH,
   parameter int B_WIDTH = ggs_pkg::RESULT_WIDTH
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  ggs_pkg::mul_ctl_type                    ctl,
   input  logic signed [A_WIDTH-1:0]               op_a,
   input  logic [B_WIDTH-1:0]                      op_b,
   output ggs_pkg::mul_sts_type                    sts,
   output logic signed [ggs_pkg::RESULT_WIDTH-1:0] result
);

   localparam int DW = ggs_pkg::DIGIT_WIDTH;
   localparam int NDIG = (B_WIDTH + DW - 1) / DW;
   localparam int BPW = NDIG * DW;
   localparam int PW = A_WIDTH + BPW;
   localparam int CNTW = $clog2(NDIG + 1);
   localparam int RSW = ggs_pkg::RESULT_WIDTH;
   localparam int SH = ggs_pkg::FRAC_SHIFT;

   logic [A_WIDTH-1:0]    mag_ff;
   logic                  neg_ff;
   logic                  shift17_ff;
   logic [BPW-1:0]        dig_ff;
   logic [PW-1:0]         acc_ff;
   logic [CNTW-1:0]       cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic signed [RSW-1:0] result_ff;

   logic [A_WIDTH-1:0]    mag_in;
   logic [A_WIDTH+DW-1:0] part;
   logic [PW-1:0]         acc_in;
   logic [PW-1:0]         quot;
   logic                  rem;
   logic                  over;
   logic [RSW-1:0]        mag_rnd;
   logic signed [RSW-1:0] result_in;

   assign mag_in = op_a[A_WIDTH-1] ? A_WIDTH'(-op_a) : A_WIDTH'(op_a);
   assign part = (A_WIDTH+DW)'(mag_ff) * (A_WIDTH+DW)'(dig_ff[BPW-1 -: DW]);
   assign acc_in = (acc_ff << DW) + PW'(part);

   // floor shift, then saturation on magnitude
   assign quot = shift17_ff ? (acc_ff >> (SH + 1)) : (acc_ff >> SH);
   assign rem = shift17_ff ? (|acc_ff[SH:0]) : (|acc_ff[SH-1:0]);
   assign over = |quot[PW-1:RSW-1];
   assign mag_rnd = quot[RSW-1:0] + RSW'(rem);

   always_comb begin
      if (!neg_ff) begin
         result_in = over ? ggs_pkg::SAT_MAX : signed'(quot[RSW-1:0]);
      end else begin
         result_in = over ? ggs_pkg::SAT_MIN : signed'(RSW'(0) - mag_rnd);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         if (ctl.start) begin
            mag_ff     <= mag_in;
            neg_ff     <= op_a[A_WIDTH-1];
            shift17_ff <= ctl.shift17;
            dig_ff     <= BPW'(op_b);
            acc_ff     <= '0;
            cnt_ff     <= CNTW'(NDIG);
            busy_ff    <= 1'b1;
            done_ff    <= 1'b0;
         end else if (busy_ff) begin
            if (cnt_ff != '0) begin
               acc_ff  <= acc_in;
               dig_ff  <= dig_ff << DW;
               cnt_ff  <= cnt_ff - CNTW'(1);
               done_ff <= 1'b0;
            end else begin
               result_ff <= result_in;
               done_ff   <= 1'b1;
               busy_ff   <= 1'b0;
            end
         end else begin
            done_ff <= 1'b0;
         end
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign result = result_ff;

endmodule

// ----- sv/ggs_colmem.sv -----
// previous price column store, one write and one registered read port
module ggs_colmem #(
   parameter int DEPTH = ggs_pkg::MAX_PRICE_POINTS_DEF + 1,
   parameter int DATA_WIDTH = ggs_pkg::VALUE_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic signed [DATA_WIDTH-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic signed [DATA_WIDTH-1:0] rd_data
);

   logic signed [DATA_WIDTH-1:0] mem [DEPTH];
   logic signed [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/ggs_rsp_fifo.sv -----
// two-entry response queue between the sequencer and the response channel
module ggs_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ggs_pkg::rsp_word_type push_word,
   input  logic                  pop,
   output ggs_pkg::rsp_word_type head_word,
   output ggs_pkg::fifo_sts_type sts
);

   localparam int DEPTH = ggs_pkg::RSP_DEPTH;
   localparam int PTRW = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH + 1);

   ggs_pkg::rsp_word_type entry_ff [DEPTH];
   logic [PTRW-1:0]       wr_ptr_ff;
   logic [PTRW-1:0]       rd_ptr_ff;
   logic [CNTW-1:0]       count_ff;
   logic                  do_push;
   logic                  do_pop;

   assign sts.full = (count_ff == CNTW'(DEPTH));
   assign sts.empty = (count_ff == '0);
   assign do_push = push && !sts.full;
   assign do_pop = pop && !sts.empty;
   assign head_word = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            entry_ff[wr_ptr_ff] <= push_word;
            wr_ptr_ff <= (wr_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTRW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTRW'(1);
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + CNTW'(1);
            2'b01:   count_ff <= count_ff - CNTW'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule
